/* rtl/versioned_min_heap_timer_queue_unit_defines.svh */
// Assertion macros used by the checker file of the timer queue.
`ifndef VERSIONED_MIN_HEAP_TIMER_QUEUE_UNIT_DEFINES_SVH
`define VERSIONED_MIN_HEAP_TIMER_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VMHTQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer queue assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VMHTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer queue assertion failed");

`endif

/* rtl/vmhtq_pkg.sv */
`timescale 1ns / 1ps
package vmhtq_pkg;

    localparam int HEAP_DEPTH = 64;
    localparam int HEAP_AW    = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = HEAP_AW + 1;
    localparam int ID_COUNT   = 256;
    localparam int ID_W       = $clog2(ID_COUNT);
    localparam int VER_W      = 16;
    localparam int CLK_W      = 40;
    localparam int EXP_W      = CLK_W + 1;
    localparam int TMO_W      = 31;
    localparam int ELP_W      = 16;
    localparam int STAT_W     = 3;
    localparam int WAIT_W     = 32;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_DEL   = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_ADDED   = 3'd0,
        ST_FULL    = 3'd1,
        ST_DELETED = 3'd2,
        ST_EXPIRED = 3'd3,
        ST_NONE    = 3'd4,
        ST_WAIT    = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_VER_RD, S_VER_INC, S_PUSH_RD, S_PUSH_CMP, S_RESP,
        S_TICK_RD, S_TICK_CHK, S_POP_RD, S_POP_CMP, S_CHK_RD, S_CHK_CMP,
        S_EMIT, S_FINISH, S_QRY_RD, S_QRY_CMP
    } state_t;

    typedef struct packed {
        logic [EXP_W-1:0] expiry;
        logic [ID_W-1:0]  id;
        logic [VER_W-1:0] ver;
    } entry_t;

    // Heap order: expiry first, then id, then version.
    function automatic logic entry_before(entry_t a, entry_t b);
        if (a.expiry != b.expiry) begin
            return a.expiry < b.expiry;
        end
        if (a.id != b.id) begin
            return a.id < b.id;
        end
        return a.ver < b.ver;
    endfunction

endpackage

/* rtl/vmhtq_ram.sv */
`timescale 1ns / 1ps
module vmhtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

/* rtl/versioned_min_heap_timer_queue_unit.sv */
`timescale 1ns / 1ps
// Add and delete read and bump the version counter; an add then sifts up, each level
// doing one parent read and one write. Tick sifts down once per popped entry, each
// sift level being one two-port read of both children and one write. One request is
// worked on at a time; results leave through a single output register. Reset clears
// the clock, the heap count and the version valid bits at once, so a request can be
// accepted as soon as reset is released.
module versioned_min_heap_timer_queue_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // mode[1:0], timer_id[9:2], timeout_ms[40:10], elapsed_ms[56:41]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // status[2:0], expired_id[10:3], wait_ms[42:11]
    output logic        m_tlast
);
    localparam int CW = vmhtq_pkg::CNT_W;
    localparam int AW = vmhtq_pkg::HEAP_AW;

    vmhtq_pkg::state_t  state_reg, state_next;
    vmhtq_pkg::mode_t   mode_reg, mode_next;
    logic [vmhtq_pkg::ID_W-1:0]  id_reg, id_next;
    logic [vmhtq_pkg::TMO_W-1:0] tmo_reg, tmo_next;
    logic [vmhtq_pkg::CLK_W-1:0] clock_reg, clock_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      idx_reg, idx_next;
    vmhtq_pkg::entry_t  cur_reg, cur_next;
    vmhtq_pkg::entry_t  top_reg, top_next;
    vmhtq_pkg::status_t resp_stat_reg, resp_stat_next;
    logic [vmhtq_pkg::WAIT_W-1:0] resp_wait_reg, resp_wait_next;
    logic               pend_reg, pend_next;
    logic [vmhtq_pkg::ID_W-1:0]  pend_id_reg, pend_id_next;

    logic               out_valid_reg;
    vmhtq_pkg::status_t out_stat_reg;
    logic [vmhtq_pkg::ID_W-1:0]   out_id_reg;
    logic [vmhtq_pkg::WAIT_W-1:0] out_wait_reg;
    logic               out_last_reg;
    logic               out_load;
    vmhtq_pkg::status_t load_stat;
    logic [vmhtq_pkg::ID_W-1:0]   load_id;
    logic [vmhtq_pkg::WAIT_W-1:0] load_wait;
    logic               load_last;
    logic               out_free;

    logic               h_we;
    logic [AW-1:0]      h_waddr, h_raddr_a, h_raddr_b;
    vmhtq_pkg::entry_t  h_wdata, h_rdata_a, h_rdata_b;

    logic [vmhtq_pkg::VER_W-1:0] ver_mem [vmhtq_pkg::ID_COUNT];
    logic [vmhtq_pkg::ID_COUNT-1:0] ver_vld_reg;
    logic [vmhtq_pkg::VER_W-1:0] ver_rdata_reg;
    logic               ver_rvld_reg;
    logic               ver_we;
    logic [vmhtq_pkg::ID_W-1:0]  ver_raddr;
    logic [vmhtq_pkg::VER_W-1:0] ver_cur, ver_inc;

    logic [vmhtq_pkg::EXP_W-1:0] clk_sum;
    logic [CW:0]        left_idx, right_idx;
    logic               left_ok, right_ok;
    vmhtq_pkg::entry_t  best;
    logic [AW-1:0]      best_idx;
    logic               best_child;
    logic [vmhtq_pkg::EXP_W-1:0] wait_diff;

    vmhtq_ram #(
        .WIDTH($bits(vmhtq_pkg::entry_t)),
        .DEPTH(vmhtq_pkg::HEAP_DEPTH)
    ) u_heap (
        .aclk   (aclk),
        .we     (h_we),
        .waddr  (h_waddr),
        .wdata  (h_wdata),
        .raddr_a(h_raddr_a),
        .rdata_a(h_rdata_a),
        .raddr_b(h_raddr_b),
        .rdata_b(h_rdata_b)
    );

    // Version counters; an id never written reads as zero through its valid bit.
    always_ff @(posedge aclk) begin
        if (ver_we) begin
            ver_mem[id_reg] <= ver_inc;
        end
        ver_rdata_reg <= ver_mem[ver_raddr];
        ver_rvld_reg  <= ver_vld_reg[ver_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ver_vld_reg <= '0;
        end else if (ver_we) begin
            ver_vld_reg[id_reg] <= 1'b1;
        end
    end

    assign ver_raddr = (state_reg == vmhtq_pkg::S_CHK_RD) ? top_reg.id : id_reg;
    assign ver_cur   = ver_rvld_reg ? ver_rdata_reg : '0;
    assign ver_inc   = ver_cur + 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == vmhtq_pkg::S_IDLE);

    assign clk_sum   = {1'b0, clock_reg} + vmhtq_pkg::EXP_W'(s_tdata[56:41]);
    assign wait_diff = (h_rdata_a.expiry > {1'b0, clock_reg})
                       ? h_rdata_a.expiry - {1'b0, clock_reg} : '0;

    // Children of the hole during sift-down.
    always_comb begin
        left_idx   = {1'b0, idx_reg, 1'b1};
        right_idx  = left_idx + 1'b1;
        left_ok    = left_idx < (CW + 1)'(count_reg);
        right_ok   = right_idx < (CW + 1)'(count_reg);
        best       = cur_reg;
        best_idx   = idx_reg;
        best_child = 1'b0;
        if (left_ok && vmhtq_pkg::entry_before(h_rdata_a, best)) begin
            best       = h_rdata_a;
            best_idx   = left_idx[AW-1:0];
            best_child = 1'b1;
        end
        if (right_ok && vmhtq_pkg::entry_before(h_rdata_b, best)) begin
            best       = h_rdata_b;
            best_idx   = right_idx[AW-1:0];
            best_child = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            vmhtq_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    unique case (vmhtq_pkg::mode_t'(s_tdata[1:0]))
                        vmhtq_pkg::MODE_ADD, vmhtq_pkg::MODE_DEL: state_next = vmhtq_pkg::S_VER_RD;
                        vmhtq_pkg::MODE_TICK:  state_next = vmhtq_pkg::S_TICK_RD;
                        vmhtq_pkg::MODE_QUERY: state_next = vmhtq_pkg::S_QRY_RD;
                        default: state_next = vmhtq_pkg::S_IDLE;
                    endcase
                end
            end
            vmhtq_pkg::S_VER_RD: state_next = vmhtq_pkg::S_VER_INC;
            vmhtq_pkg::S_VER_INC: begin
                if (mode_reg == vmhtq_pkg::MODE_ADD
                        && count_reg < CW'(vmhtq_pkg::HEAP_DEPTH)) begin
                    state_next = vmhtq_pkg::S_PUSH_RD;
                end else begin
                    state_next = vmhtq_pkg::S_RESP;
                end
            end
            vmhtq_pkg::S_PUSH_RD: begin
                state_next = (idx_reg == '0) ? vmhtq_pkg::S_RESP : vmhtq_pkg::S_PUSH_CMP;
            end
            vmhtq_pkg::S_PUSH_CMP: begin
                state_next = vmhtq_pkg::entry_before(cur_reg, h_rdata_a)
                             ? vmhtq_pkg::S_PUSH_RD : vmhtq_pkg::S_RESP;
            end
            vmhtq_pkg::S_RESP:     if (out_free) state_next = vmhtq_pkg::S_IDLE;
            vmhtq_pkg::S_TICK_RD:  state_next = vmhtq_pkg::S_TICK_CHK;
            vmhtq_pkg::S_TICK_CHK: begin
                if (count_reg != '0 && h_rdata_a.expiry <= {1'b0, clock_reg}) begin
                    state_next = vmhtq_pkg::S_POP_RD;
                end else begin
                    state_next = vmhtq_pkg::S_FINISH;
                end
            end
            vmhtq_pkg::S_POP_RD:  state_next = vmhtq_pkg::S_POP_CMP;
            vmhtq_pkg::S_POP_CMP: begin
                state_next = best_child ? vmhtq_pkg::S_POP_RD : vmhtq_pkg::S_CHK_RD;
            end
            vmhtq_pkg::S_CHK_RD:  state_next = vmhtq_pkg::S_CHK_CMP;
            vmhtq_pkg::S_CHK_CMP: begin
                if (ver_cur == top_reg.ver && pend_reg) begin
                    state_next = vmhtq_pkg::S_EMIT;
                end else begin
                    state_next = vmhtq_pkg::S_TICK_RD;
                end
            end
            vmhtq_pkg::S_EMIT:    if (out_free) state_next = vmhtq_pkg::S_TICK_RD;
            vmhtq_pkg::S_FINISH:  if (out_free) state_next = vmhtq_pkg::S_IDLE;
            vmhtq_pkg::S_QRY_RD:  state_next = vmhtq_pkg::S_QRY_CMP;
            vmhtq_pkg::S_QRY_CMP: state_next = vmhtq_pkg::S_RESP;
            default:              state_next = vmhtq_pkg::S_IDLE;
        endcase
    end

    // Datapath, memory ports and result loading.
    always_comb begin
        mode_next      = mode_reg;
        id_next        = id_reg;
        tmo_next       = tmo_reg;
        clock_next     = clock_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        top_next       = top_reg;
        resp_stat_next = resp_stat_reg;
        resp_wait_next = resp_wait_reg;
        pend_next      = pend_reg;
        pend_id_next   = pend_id_reg;
        h_we           = 1'b0;
        h_waddr        = idx_reg;
        h_wdata        = cur_reg;
        h_raddr_a      = '0;
        h_raddr_b      = '0;
        ver_we         = 1'b0;
        out_load       = 1'b0;
        load_stat      = resp_stat_reg;
        load_id        = '0;
        load_wait      = '0;
        load_last      = 1'b1;
        unique case (state_reg)
            vmhtq_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    mode_next      = vmhtq_pkg::mode_t'(s_tdata[1:0]);
                    id_next        = s_tdata[9:2];
                    tmo_next       = s_tdata[40:10];
                    resp_wait_next = '0;
                    if (vmhtq_pkg::mode_t'(s_tdata[1:0]) == vmhtq_pkg::MODE_TICK) begin
                        // The clock saturates instead of wrapping.
                        clock_next = clk_sum[vmhtq_pkg::CLK_W] ? '1
                                     : clk_sum[vmhtq_pkg::CLK_W-1:0];
                    end
                end
            end
            vmhtq_pkg::S_VER_INC: begin
                ver_we = 1'b1;
                if (mode_reg == vmhtq_pkg::MODE_DEL) begin
                    resp_stat_next = vmhtq_pkg::ST_DELETED;
                end else if (count_reg >= CW'(vmhtq_pkg::HEAP_DEPTH)) begin
                    resp_stat_next = vmhtq_pkg::ST_FULL;
                end else begin
                    resp_stat_next = vmhtq_pkg::ST_ADDED;
                    cur_next.expiry = {1'b0, clock_reg} + vmhtq_pkg::EXP_W'(tmo_reg);
                    cur_next.id     = id_reg;
                    cur_next.ver    = ver_inc;
                    idx_next        = count_reg[AW-1:0];
                    count_next      = count_reg + 1'b1;
                end
            end
            vmhtq_pkg::S_PUSH_RD: begin
                h_raddr_a = (idx_reg - 1'b1) >> 1;
                if (idx_reg == '0) begin
                    h_we = 1'b1;
                end
            end
            vmhtq_pkg::S_PUSH_CMP: begin
                h_we = 1'b1;
                if (vmhtq_pkg::entry_before(cur_reg, h_rdata_a)) begin
                    h_wdata  = h_rdata_a;
                    idx_next = (idx_reg - 1'b1) >> 1;
                end
            end
            vmhtq_pkg::S_RESP: begin
                out_load = out_free;
                load_wait = resp_wait_reg;
            end
            vmhtq_pkg::S_TICK_RD: begin
                h_raddr_b = AW'(count_reg - 1'b1);
            end
            vmhtq_pkg::S_TICK_CHK: begin
                if (count_reg != '0 && h_rdata_a.expiry <= {1'b0, clock_reg}) begin
                    top_next   = h_rdata_a;
                    cur_next   = h_rdata_b;
                    count_next = count_reg - 1'b1;
                    idx_next   = '0;
                end
            end
            vmhtq_pkg::S_POP_RD: begin
                h_raddr_a = left_idx[AW-1:0];
                h_raddr_b = right_idx[AW-1:0];
            end
            vmhtq_pkg::S_POP_CMP: begin
                h_we    = 1'b1;
                h_wdata = best;
                idx_next = best_idx;
                if (!best_child) begin
                    h_wdata = cur_reg;
                end
            end
            vmhtq_pkg::S_CHK_CMP: begin
                // A matching pop is held back until we know whether it is the last.
                if (ver_cur == top_reg.ver && !pend_reg) begin
                    pend_next    = 1'b1;
                    pend_id_next = top_reg.id;
                end
            end
            vmhtq_pkg::S_EMIT: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    load_stat    = vmhtq_pkg::ST_EXPIRED;
                    load_id      = pend_id_reg;
                    load_last    = 1'b0;
                    pend_id_next = top_reg.id;
                end
            end
            vmhtq_pkg::S_FINISH: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    load_stat = pend_reg ? vmhtq_pkg::ST_EXPIRED : vmhtq_pkg::ST_NONE;
                    load_id   = pend_reg ? pend_id_reg : '0;
                    pend_next = 1'b0;
                end
            end
            vmhtq_pkg::S_QRY_CMP: begin
                resp_stat_next = vmhtq_pkg::ST_WAIT;
                resp_wait_next = (count_reg == '0) ? '1 : wait_diff[vmhtq_pkg::WAIT_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= vmhtq_pkg::S_IDLE;
            clock_reg     <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clock_reg <= clock_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        id_reg        <= id_next;
        tmo_reg       <= tmo_next;
        idx_reg       <= idx_next;
        cur_reg       <= cur_next;
        top_reg       <= top_next;
        resp_stat_reg <= resp_stat_next;
        resp_wait_reg <= resp_wait_next;
        pend_id_reg   <= pend_id_next;
        if (out_load) begin
            out_stat_reg <= load_stat;
            out_id_reg   <= load_id;
            out_wait_reg <= load_wait;
            out_last_reg <= load_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_wait_reg, out_id_reg, out_stat_reg};
    assign m_tlast  = out_last_reg;
endmodule

/* rtl/vmhtq_checker.sv */
`timescale 1ns / 1ps
`include "versioned_min_heap_timer_queue_unit_defines.svh"
module vmhtq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);
    // A stalled result must stay offered.
    `VMHTQ_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // Only tick results can be followed by more results of the same request.
    `VMHTQ_ASSERT_NOW(a_last, aclk, aresetn, m_tvalid && m_tdata[2:0] != vmhtq_pkg::ST_EXPIRED, m_tlast)
    // The wait field is zero on every result but a query.
    `VMHTQ_ASSERT_NOW(a_wait, aclk, aresetn, m_tvalid && m_tdata[2:0] != vmhtq_pkg::ST_WAIT, m_tdata[42:11] == 32'd0)
    // The id field is zero on every result but an expiry.
    `VMHTQ_ASSERT_NOW(a_id, aclk, aresetn, m_tvalid && m_tdata[2:0] != vmhtq_pkg::ST_EXPIRED, m_tdata[10:3] == 8'd0)
    // A new request is taken only after the previous accept moved the block off idle.
    `VMHTQ_ASSERT_NEXT(a_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)
endmodule

bind versioned_min_heap_timer_queue_unit vmhtq_checker u_vmhtq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);
